### rtl/wbb_pkg.sv
// Shared constants, request codes, types and sizing functions for the block bitmap.
`default_nettype none

package wbb_pkg;

    localparam int MAX_BLOCKS_DEF = 4096;

    localparam int FIRST_W     = 32;
    localparam int COUNT_W     = 12;
    localparam int REQ_W       = 3;
    localparam int INDEX_W     = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;
    localparam int ALIGN_W     = 3;
    localparam int RAW_LEN_W   = COUNT_W + 1;
    localparam int MAX_ROWS    = 256;
    localparam int SMALL_LIMIT = 2048;
    localparam int MIN_ROW_LOG = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BLOCK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    localparam logic [REQ_W-1:0] REQ_GET       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_SET       = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_SET_ALL   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_CLEAR_ALL = 3'd4;

    // Decoded request, carried from the request port to the map stage
    typedef struct packed {
        logic bit_req;   // single-bit request inside the window
        logic set_bit;
        logic clr_bit;
        logic all_req;   // whole-window request on a non-empty window
        logic all_val;
    } op_t;

    typedef struct packed {
        logic bit_value;
        logic ok;
        logic all_set;
    } res_t;

    function automatic int len_width(input int max_blocks);
        return $clog2(max_blocks + 1);
    endfunction

    function automatic int row_log(input int max_blocks);
        return (max_blocks > SMALL_LIMIT) ? $clog2(max_blocks) - 8 : MIN_ROW_LOG;
    endfunction

    function automatic int row_count(input int max_blocks);
        int rl;
        rl = row_log(max_blocks);
        return (max_blocks + (1 << rl) - 1) >> rl;
    endfunction

    function automatic int row_addr_width(input int max_blocks);
        int rows;
        rows = row_count(max_blocks);
        return (rows > 1) ? $clog2(rows) : 1;
    endfunction

endpackage

`default_nettype wire

### rtl/wbb_cfg_regs.sv
// Configuration registers and window base and length for the block bitmap.
`default_nettype none

module wbb_cfg_regs
    import wbb_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int LW         = len_width(MAX_BLOCKS_DEF)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic      [INDEX_W-1:0]    win_base,
    output logic      [LW-1:0]         win_len,
    output logic                       map_clear
);

    logic [FIRST_W-1:0]   first_block_reg;
    logic [COUNT_W-1:0]   block_count_reg;
    logic [RAW_LEN_W-1:0] raw_len;
    logic [31:0]          raw_len32;
    logic [31:0]          len32;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            first_block_reg <= '0;
            block_count_reg <= '0;
        end
        else if (cfg_we) begin
            unique case (cfg_idx)
                CFG_FIRST_BLOCK: first_block_reg <= cfg_wdata[FIRST_W-1:0];
                CFG_BLOCK_COUNT: block_count_reg <= cfg_wdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Every register write wipes the map
    assign map_clear = cfg_we;

    assign win_base  = {first_block_reg[FIRST_W-1:ALIGN_W], {ALIGN_W{1'b0}}};
    assign raw_len   = {1'b0, block_count_reg}
                     + {{(RAW_LEN_W-ALIGN_W){1'b0}}, first_block_reg[ALIGN_W-1:0]};
    assign raw_len32 = 32'(raw_len);

    always_comb
    begin
        if (block_count_reg == '0)
            len32 = '0;
        else if (raw_len32 > 32'(MAX_BLOCKS))
            len32 = 32'(MAX_BLOCKS);
        else
            len32 = raw_len32;
    end

    assign win_len = len32[LW-1:0];

endmodule

`default_nettype wire

### rtl/wbb_decode.sv
// Request decode and window check for the block bitmap.
`default_nettype none

module wbb_decode
    import wbb_pkg::*;
#(
    parameter int LW      = len_width(MAX_BLOCKS_DEF),
    parameter int ROW_LOG = row_log(MAX_BLOCKS_DEF),
    parameter int ROW_AW  = row_addr_width(MAX_BLOCKS_DEF)
)
(
    input  wire logic [REQ_W-1:0]   req_type,
    input  wire logic [INDEX_W-1:0] block_index,
    input  wire logic [INDEX_W-1:0] win_base,
    input  wire logic [LW-1:0]      win_len,
    output op_t                     op,
    output logic      [ROW_AW-1:0]  row,
    output logic      [ROW_LOG-1:0] col
);

    logic [INDEX_W-1:0] diff;
    logic               in_win;
    logic               is_bit;
    logic               is_all;
    logic [LW-1:0]      k;
    logic [LW-1:0]      k_row;

    assign diff   = block_index - win_base;
    assign in_win = (block_index >= win_base) && (diff < 32'(win_len));

    always_comb
    begin
        is_bit = 1'b0;
        is_all = 1'b0;
        unique case (req_type) inside
            REQ_GET, REQ_SET, REQ_CLEAR: is_bit = 1'b1;
            REQ_SET_ALL, REQ_CLEAR_ALL:  is_all = 1'b1;
            default:                     ;
        endcase
    end

    assign op.bit_req = is_bit && in_win;
    assign op.set_bit = op.bit_req && (req_type == REQ_SET);
    assign op.clr_bit = op.bit_req && (req_type == REQ_CLEAR);
    assign op.all_req = is_all && (win_len != '0);
    assign op.all_val = (req_type == REQ_SET_ALL);

    assign k     = diff[LW-1:0];
    assign k_row = k >> ROW_LOG;
    assign row   = k_row[ROW_AW-1:0];
    assign col   = k[ROW_LOG-1:0];

endmodule

`default_nettype wire

### rtl/wbb_map.sv
// Row memory with row valid bits, fill value and running set count.
`default_nettype none

module wbb_map
    import wbb_pkg::*;
#(
    parameter int LW       = len_width(MAX_BLOCKS_DEF),
    parameter int ROW_LOG  = row_log(MAX_BLOCKS_DEF),
    parameter int ROWS     = row_count(MAX_BLOCKS_DEF),
    parameter int ROW_AW   = row_addr_width(MAX_BLOCKS_DEF),
    parameter int ROW_BITS = 1 << ROW_LOG
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               map_clear,
    input  wire logic [LW-1:0]      win_len,
    input  wire logic               rd_en,
    input  wire logic [ROW_AW-1:0]  rd_row,
    input  wire logic               s_fire,
    input  wire op_t                s_op,
    input  wire logic [ROW_AW-1:0]  s_row,
    input  wire logic [ROW_LOG-1:0] s_col,
    output res_t                    res
);

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rdata_reg;
    logic [ROWS-1:0]     row_valid_reg;
    logic                fill_reg;
    logic [LW-1:0]       set_count_reg;
    logic [LW-1:0]       set_count_next;

    logic [ROW_BITS-1:0] cur_row;
    logic [ROW_BITS-1:0] new_row;
    logic                old_bit;
    logic                new_bit;
    logic                wr;

    // A row never written since the last whole-map action reads as the fill value
    assign cur_row = row_valid_reg[s_row] ? rdata_reg : {ROW_BITS{fill_reg}};
    assign old_bit = cur_row[s_col];
    assign new_bit = s_op.set_bit ? 1'b1 : (s_op.clr_bit ? 1'b0 : old_bit);
    assign wr      = s_fire && (s_op.set_bit || s_op.clr_bit);

    always_comb
    begin
        new_row        = cur_row;
        new_row[s_col] = new_bit;
    end

    always_comb
    begin
        set_count_next = set_count_reg;
        if (s_op.all_req)
            set_count_next = s_op.all_val ? win_len : '0;
        else if (s_op.set_bit && !old_bit)
            set_count_next = set_count_reg + 1'b1;
        else if (s_op.clr_bit && old_bit)
            set_count_next = set_count_reg - 1'b1;
    end

    assign res.ok        = s_op.bit_req || s_op.all_req;
    assign res.bit_value = s_op.bit_req ? new_bit : (s_op.all_req && s_op.all_val);
    assign res.all_set   = (set_count_next == win_len);

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[s_row] <= new_row;
    end

    // Forward the row being written when the incoming request reads it
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= (wr && (rd_row == s_row)) ? new_row : mem[rd_row];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            row_valid_reg <= '0;
            fill_reg      <= 1'b0;
            set_count_reg <= '0;
        end
        else if (map_clear) begin
            row_valid_reg <= '0;
            fill_reg      <= 1'b0;
            set_count_reg <= '0;
        end
        else if (s_fire) begin
            set_count_reg <= set_count_next;
            if (s_op.all_req) begin
                row_valid_reg <= '0;
                fill_reg      <= s_op.all_val;
            end
            else if (wr) begin
                row_valid_reg[s_row] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/windowed_block_bitmap.sv
// Windowed block have-bit map: top level with request and result registers.
// Pipeline: map stage register, then the output register holding the result.
// Throughput: one request per cycle while results drain; row read-modify-write
//   with map-stage forwarding keeps back-to-back same-row requests correct.
// Reset: asynchronous active low; clears configuration, row valid bits, fill
//   value and set count; the row memory itself is never cleared, no clearing pass.
`default_nettype none

module windowed_block_bitmap
    import wbb_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [REQ_W-1:0]      req_type,
    input  wire logic [INDEX_W-1:0]    block_index,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       bit_value,
    output logic                       ok,
    output logic                       all_set,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int LW       = len_width(MAX_BLOCKS);
    localparam int ROW_LOG  = row_log(MAX_BLOCKS);
    localparam int ROW_BITS = 1 << ROW_LOG;
    localparam int ROWS     = row_count(MAX_BLOCKS);
    localparam int ROW_AW   = row_addr_width(MAX_BLOCKS);

    logic [INDEX_W-1:0] win_base;
    logic [LW-1:0]      win_len;
    logic               map_clear;

    op_t                in_op;
    logic [ROW_AW-1:0]  in_row;
    logic [ROW_LOG-1:0] in_col;

    // map stage: decoded request waiting for its row data
    logic               s_valid_reg;
    op_t                s_op_reg;
    logic [ROW_AW-1:0]  s_row_reg;
    logic [ROW_LOG-1:0] s_col_reg;

    // result register
    logic               out_valid_reg;
    res_t               out_res_reg;

    res_t               map_res;
    logic               advance;
    logic               in_fire;

    wbb_cfg_regs #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .LW         (LW)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .win_base  (win_base),
        .win_len   (win_len),
        .map_clear (map_clear)
    );

    // Decode at the port so the row read goes out with the accept
    wbb_decode #(
        .LW      (LW),
        .ROW_LOG (ROW_LOG),
        .ROW_AW  (ROW_AW)
    ) u_dec (
        .req_type    (req_type),
        .block_index (block_index),
        .win_base    (win_base),
        .win_len     (win_len),
        .op          (in_op),
        .row         (in_row),
        .col         (in_col)
    );

    // Advance the map stage when the result register is empty or being drained
    assign advance  = s_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s_valid_reg || advance;
    assign in_fire  = in_valid && in_ready;

    wbb_map #(
        .LW       (LW),
        .ROW_LOG  (ROW_LOG),
        .ROWS     (ROWS),
        .ROW_AW   (ROW_AW),
        .ROW_BITS (ROW_BITS)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .map_clear (map_clear),
        .win_len   (win_len),
        .rd_en     (in_fire),
        .rd_row    (in_row),
        .s_fire    (advance),
        .s_op      (s_op_reg),
        .s_row     (s_row_reg),
        .s_col     (s_col_reg),
        .res       (map_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_valid_reg <= 1'b0;
        end
        else if (in_fire) begin
            s_valid_reg <= 1'b1;
        end
        else if (advance) begin
            s_valid_reg <= 1'b0;
        end
    end

    // Hold the decoded request while the stage is stalled
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            s_op_reg  <= in_op;
            s_row_reg <= in_row;
            s_col_reg <= in_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end
        else if (advance) begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= map_res;
    end

    assign out_valid = out_valid_reg;
    assign bit_value = out_res_reg.bit_value;
    assign ok        = out_res_reg.ok;
    assign all_set   = out_res_reg.all_set;

    // A refused request never reports a set bit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> !bit_value)
        else $error("refused request reports bit_value high");

    // A set-all on a non-empty window leaves every window bit present
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s_op_reg.all_req && s_op_reg.all_val |=> out_valid && ok && all_set)
        else $error("set all did not report all_set");

    // An accepted single-bit set reads back as set
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s_op_reg.set_bit |=> out_valid && ok && bit_value)
        else $error("set bit did not read back as set");

endmodule

`default_nettype wire
